// ----- rtl/sorted_priority_queue_defines.svh -----
// Assertion macros for the sorted priority queue.
// Included by modules that carry concurrent checks; expects clk and rst in scope.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SPQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, disabled during reset.
`define SPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ----- rtl/spq_pkg.sv -----
// Shared types and constants for the sorted priority queue.
// No dependencies; used by the interfaces, the cell and the top level.
`timescale 1ns / 1ps

package spq_pkg;

  localparam int PRIO_W = 8;
  localparam int TAG_W  = 16;
  localparam int CNT_W  = 5;

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  // Broadcast to every cell of the chain
  typedef struct packed {
    logic insert;  // place the new entry, shift the tail back by one
    logic pop;     // shift everything toward the front by one
  } cell_ctl_t;

endpackage

// ----- rtl/spq_if.sv -----
// Valid/ready channel interfaces for the sorted priority queue.
// Depends on spq_pkg for field widths.
`timescale 1ns / 1ps

interface spq_req_if import spq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [PRIO_W-1:0] priority_req;
  logic [TAG_W-1:0]  tag;

  modport source (output valid, command, priority_req, tag, input ready);
  modport sink   (input valid, command, priority_req, tag, output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TAG_W-1:0]  out_tag;
  logic [PRIO_W-1:0] out_priority;
  logic              empty_res;
  logic              full_drop;
  logic [CNT_W-1:0]  count;

  modport source (output valid, out_tag, out_priority, empty_res, full_drop, count,
                  input ready);
  modport sink   (input valid, out_tag, out_priority, empty_res, full_drop, count,
                  output ready);
endinterface

// ----- rtl/spq_cell.sv -----
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
// Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_cell import spq_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      occupied,   // slot lies below the current fill level
  input  entry_t    new_entry,  // broadcast insert payload
  input  entry_t    left_entry, // neighbor nearer the front
  input  logic      left_keep,  // neighbor keeps its entry on insert
  input  entry_t    right_entry,
  output entry_t    entry,
  output logic      keep
);

  // Hold when this entry ranks at or above the newcomer (older wins ties)
  assign keep = occupied && (entry.prio >= new_entry.prio);

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      entry <= right_entry;
    end else if (ctl.insert && !keep) begin
      entry <= left_keep ? new_entry : left_entry;
    end
  end

endmodule

// ----- rtl/sorted_priority_queue.sv -----
// Sorted priority queue of request handles, built as a chain of DEPTH cells that
// each hold one {priority, tag} entry, front of the queue in cell 0. An insert beat
// is broadcast to every cell at once: cells whose entry ranks at or above the new
// priority hold, the first cell that does not takes the new entry, and every cell
// behind it takes its front neighbor's entry, so equal priorities leave in arrival
// order. A pop beat returns cell 0 and moves every entry one cell forward. The
// result beat appears in an output register in the cycle after the request beat,
// and the block takes one item per cycle as long as results are drained. A pop on
// an empty queue reports empty_res, an insert on a full queue is dropped and reports
// full_drop, and every result carries the entry count after the item (low five
// bits). Cell contents need no reset: only cells below the fill count are ever read.
`timescale 1ns / 1ps

module sorted_priority_queue import spq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst,
  spq_req_if.sink   req,
  spq_rsp_if.source rsp
);

  `include "sorted_priority_queue_defines.svh"

  localparam int OCC_W = $clog2(DEPTH + 1);

  logic [OCC_W-1:0] occupancy;
  logic [OCC_W-1:0] occupancy_next;
  logic             res_valid;

  entry_t            cell_entry [DEPTH];
  logic [DEPTH-1:0]  cell_keep;
  logic [DEPTH-1:0]  occ_vec;
  entry_t            new_entry;
  cell_ctl_t         ctl;

  logic accept;
  logic is_pop;
  logic q_empty;
  logic q_full;

  // Outside reset, take a new beat whenever the result register is free or draining
  assign req.ready = !rst && (!res_valid || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign is_pop    = (req.command == CMD_POP);

  assign q_empty = (occupancy == '0);
  assign q_full  = (occupancy == OCC_W'(DEPTH));

  assign new_entry.prio = req.priority_req;
  assign new_entry.tag  = req.tag;

  // Drop inserts into a full queue and pops from an empty one
  assign ctl.insert = accept && !is_pop && !q_full;
  assign ctl.pop    = accept && is_pop && !q_empty;

  always_comb begin
    occupancy_next = occupancy;
    if (ctl.insert) begin
      occupancy_next = occupancy + OCC_W'(1);
    end else if (ctl.pop) begin
      occupancy_next = occupancy - OCC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else begin
      occupancy <= occupancy_next;
    end
  end

  // The chain: cell 0 is the front; its front neighbor always "keeps"
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_entry;
    logic   left_keep;
    entry_t right_entry;

    assign occ_vec[i] = (OCC_W'(i) < occupancy);

    if (i == 0) begin : g_front
      assign left_entry = new_entry;
      assign left_keep  = 1'b1;
    end else begin : g_inner
      assign left_entry = cell_entry[i-1];
      assign left_keep  = cell_keep[i-1];
    end

    if (i == DEPTH - 1) begin : g_back
      assign right_entry = cell_entry[i];
    end else begin : g_mid
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occupied    (occ_vec[i]),
      .new_entry   (new_entry),
      .left_entry  (left_entry),
      .left_keep   (left_keep),
      .right_entry (right_entry),
      .entry       (cell_entry[i]),
      .keep        (cell_keep[i])
    );
  end

  // Result register: hold until the sink takes the beat
  logic [OCC_W+CNT_W-1:0] occ_wide;
  assign occ_wide = {{CNT_W{1'b0}}, occupancy_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (rsp.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.out_tag      <= ctl.pop ? cell_entry[0].tag  : '0;
      rsp.out_priority <= ctl.pop ? cell_entry[0].prio : '0;
      rsp.empty_res    <= is_pop && q_empty;
      rsp.full_drop    <= !is_pop && q_full;
      rsp.count        <= occ_wide[CNT_W-1:0];
    end
  end

  assign rsp.valid = res_valid;

  // Checks
  `SPQ_ASSERT_NOW(a_occ_bound, 1'b1, occupancy <= OCC_W'(DEPTH))
  `SPQ_ASSERT_NEXT(a_pop_dec, accept && is_pop && !q_empty,
    occupancy == $past(occupancy) - OCC_W'(1))
  `SPQ_ASSERT_NEXT(a_full_drop, accept && !is_pop && q_full,
    rsp.full_drop && occupancy == $past(occupancy))
  `SPQ_ASSERT_NEXT(a_result_up, accept, res_valid)
  `SPQ_ASSERT_NOW(a_front_sorted, occupancy >= OCC_W'(2),
    cell_entry[0].prio >= cell_entry[1].prio)

endmodule
